// File: rtl/cpbd_pkg.sv
// Shared widths, register codes, item types and the per-axis clipping function.
package cpbd_pkg;

    localparam int HEAT_W      = 16;
    localparam int OFFSET_W    = 16;
    localparam int SIZE_W      = 16;
    localparam int CELL_W      = 10;
    localparam int CLASS_W     = 4;
    localparam int PPC_W       = 24;
    localparam int FRAME_W     = 14;
    localparam int POS_W       = 13;
    localparam int PPC_FRAC    = 16;
    localparam int FRAC_BITS   = 25;
    localparam int CTR_SHIFT   = FRAC_BITS - PPC_FRAC;
    localparam int OP_W        = 21;
    localparam int PROD_W      = OP_W + PPC_W + 1;
    localparam int RND_W       = PROD_W - FRAC_BITS;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 24;
    localparam int QUEUE_DEPTH = 4;
    localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);
    localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

    localparam logic [FRAME_W-1:0] FRAME_MAX     = FRAME_W'(8192);
    localparam logic [HEAT_W-1:0]  RST_THRESHOLD = HEAT_W'(26214);
    localparam logic [PPC_W-1:0]   RST_PPC       = PPC_W'(262144);
    localparam logic [FRAME_W-1:0] RST_IMG_W     = FRAME_W'(1920);
    localparam logic [FRAME_W-1:0] RST_IMG_H     = FRAME_W'(1080);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SCORE_THRESHOLD = 2'd0,
        CFG_PIXELS_PER_CELL = 2'd1,
        CFG_IMG_W           = 2'd2,
        CFG_IMG_H           = 2'd3
    } t_cfg_reg;

    typedef struct packed {
        logic [HEAT_W-1:0]  score_threshold;
        logic [PPC_W-1:0]   pixels_per_cell;
        logic [FRAME_W-1:0] img_w;
        logic [FRAME_W-1:0] img_h;
    } t_cfg;

    // A kept peak with its corner operands in Q.9 cell units.
    typedef struct packed {
        logic signed [OP_W-1:0] lo_x;
        logic signed [OP_W-1:0] hi_x;
        logic signed [OP_W-1:0] lo_y;
        logic signed [OP_W-1:0] hi_y;
        logic [HEAT_W-1:0]      score;
        logic [CLASS_W-1:0]     out_class;
        logic [CELL_W-1:0]      peak_x;
        logic [CELL_W-1:0]      peak_y;
    } t_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef struct packed {
        logic               ok;
        logic [POS_W-1:0]   start;
        logic [FRAME_W-1:0] len;
    } t_span;

    // Rounds both corner products half up, clips them to the frame and checks the span.
    function automatic t_span axis_clip(input logic signed [PROD_W-1:0] p_lo,
                                        input logic signed [PROD_W-1:0] p_hi,
                                        input logic [FRAME_W-1:0] limit);
        logic signed [RND_W-1:0] lo_r;
        logic signed [RND_W-1:0] hi_t;
        logic signed [RND_W:0]   hi_r;
        logic signed [RND_W:0]   lo_c;
        logic signed [RND_W:0]   hi_c;
        logic signed [RND_W:0]   lim_s;
        logic [FRAME_W-1:0]      lim;
        t_span                   s;
        lo_r = $signed(p_lo[PROD_W-1:FRAC_BITS])
             + $signed({{(RND_W-1){1'b0}}, p_lo[FRAC_BITS-1]});
        hi_t = $signed(p_hi[PROD_W-1:FRAC_BITS])
             + $signed({{(RND_W-1){1'b0}}, p_hi[FRAC_BITS-1]});
        hi_r = $signed({hi_t[RND_W-1], hi_t}) + $signed((RND_W+1)'(1));
        lim = (limit > FRAME_MAX) ? FRAME_MAX : limit;
        lim_s = $signed((RND_W+1)'(lim));
        lo_c = lo_r[RND_W-1] ? '0 : $signed({1'b0, lo_r});
        hi_c = (hi_r > lim_s) ? lim_s : hi_r;
        s.ok = hi_c > lo_c;
        s.start = POS_W'(lo_c);
        s.len = FRAME_W'(hi_c - lo_c);
        return s;
    endfunction

endpackage

// File: rtl/cpbd_in_if.sv
// Heatmap cell channel: valid, ready and one cell's fields.
interface cpbd_in_if;
    logic                                 valid;
    logic                                 ready;
    logic [cpbd_pkg::HEAT_W-1:0]          heat;
    logic [cpbd_pkg::HEAT_W-1:0]          pooled_heat;
    logic signed [cpbd_pkg::OFFSET_W-1:0] offset_x;
    logic signed [cpbd_pkg::OFFSET_W-1:0] offset_y;
    logic [cpbd_pkg::SIZE_W-1:0]          size_w;
    logic [cpbd_pkg::SIZE_W-1:0]          size_h;
    logic [cpbd_pkg::CELL_W-1:0]          cell_x;
    logic [cpbd_pkg::CELL_W-1:0]          cell_y;
    logic [cpbd_pkg::CLASS_W-1:0]         class_index;

    modport source (
        output valid, heat, pooled_heat, offset_x, offset_y, size_w, size_h,
               cell_x, cell_y, class_index,
        input  ready
    );
    modport sink (
        input  valid, heat, pooled_heat, offset_x, offset_y, size_w, size_h,
               cell_x, cell_y, class_index,
        output ready
    );
endinterface

// File: rtl/cpbd_out_if.sv
// Detection channel: valid, ready and one decoded box.
interface cpbd_out_if;
    logic                          valid;
    logic                          ready;
    logic [cpbd_pkg::POS_W-1:0]    box_x;
    logic [cpbd_pkg::POS_W-1:0]    box_y;
    logic [cpbd_pkg::FRAME_W-1:0]  box_w;
    logic [cpbd_pkg::FRAME_W-1:0]  box_h;
    logic [cpbd_pkg::HEAT_W-1:0]   score;
    logic [cpbd_pkg::CLASS_W-1:0]  out_class;
    logic [cpbd_pkg::CELL_W-1:0]   peak_x;
    logic [cpbd_pkg::CELL_W-1:0]   peak_y;

    modport source (
        output valid, box_x, box_y, box_w, box_h, score, out_class, peak_x, peak_y,
        input  ready
    );
    modport sink (
        input  valid, box_x, box_y, box_w, box_h, score, out_class, peak_x, peak_y,
        output ready
    );
endinterface

// File: rtl/cpbd_cfg_if.sv
// Configuration write channel: valid, ready, register index and write data.
interface cpbd_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [cpbd_pkg::CFG_IDX_W-1:0]   index;
    logic [cpbd_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/cpbd_front.sv
// Front end: accepts cells, picks out peaks and forms the corner operands.
module cpbd_front #(
    parameter int NUM_CLASSES = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    cpbd_in_if.sink                     i_cell,
    input  logic [cpbd_pkg::HEAT_W-1:0] i_score_threshold,
    input  cpbd_pkg::t_q_status         i_q,
    output logic                        o_push,
    output cpbd_pkg::t_item             o_item
);
    import cpbd_pkg::*;

    logic                   r_valid;
    logic                   n_valid;
    t_item                  r_item;
    t_item                  n_item;
    logic                   take;
    logic                   accept;
    logic                   keep;
    logic                   class_ok;
    logic signed [OP_W-1:0] ctr_x;
    logic signed [OP_W-1:0] ctr_y;

    assign take = r_valid && !i_q.full;
    assign i_cell.ready = !r_valid || !i_q.full;
    assign accept = i_cell.valid && i_cell.ready;

    assign class_ok = 32'(i_cell.class_index) < NUM_CLASSES;
    assign keep = class_ok && (i_cell.heat == i_cell.pooled_heat)
               && (i_cell.pooled_heat > i_score_threshold);

    // Centre in Q.9 cells: the column shifted up plus twice the Q8.8 offset.
    assign ctr_x = $signed(OP_W'({i_cell.cell_x, {CTR_SHIFT{1'b0}}}))
                 + $signed({{(OP_W-OFFSET_W-1){i_cell.offset_x[OFFSET_W-1]}},
                            i_cell.offset_x, 1'b0});
    assign ctr_y = $signed(OP_W'({i_cell.cell_y, {CTR_SHIFT{1'b0}}}))
                 + $signed({{(OP_W-OFFSET_W-1){i_cell.offset_y[OFFSET_W-1]}},
                            i_cell.offset_y, 1'b0});

    always_comb begin
        n_item.lo_x = ctr_x - $signed(OP_W'(i_cell.size_w));
        n_item.hi_x = ctr_x + $signed(OP_W'(i_cell.size_w));
        n_item.lo_y = ctr_y - $signed(OP_W'(i_cell.size_h));
        n_item.hi_y = ctr_y + $signed(OP_W'(i_cell.size_h));
        n_item.score = i_cell.pooled_heat;
        n_item.out_class = i_cell.class_index;
        n_item.peak_x = i_cell.cell_x;
        n_item.peak_y = i_cell.cell_y;
    end

    assign n_valid = (accept && keep) || (r_valid && !take);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && keep) begin
            r_item <= n_item;
        end
    end

    assign o_push = take;
    assign o_item = r_item;

endmodule

// File: rtl/cpbd_queue.sv
// Short queue of kept peaks between the front end and the box arithmetic.
module cpbd_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  cpbd_pkg::t_item     i_item,
    input  logic                i_pop,
    output cpbd_pkg::t_item     o_item,
    output cpbd_pkg::t_q_status o_status
);
    import cpbd_pkg::*;

    t_item              r_mem [QUEUE_DEPTH];
    logic [Q_PTR_W-1:0] r_wr;
    logic [Q_PTR_W-1:0] r_rd;
    logic [Q_CNT_W-1:0] r_count;
    logic [Q_PTR_W-1:0] n_wr;
    logic [Q_PTR_W-1:0] n_rd;
    logic [Q_CNT_W-1:0] n_count;

    always_comb begin
        n_wr = r_wr;
        n_rd = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + Q_PTR_W'(1);
        end
        if (i_pop) begin
            n_rd = (r_rd == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + Q_PTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + Q_CNT_W'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - Q_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
            r_count <= '0;
        end else begin
            r_wr <= n_wr;
            r_rd <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    assign o_item = r_mem[r_rd];
    assign o_status.full = r_count == Q_CNT_W'(QUEUE_DEPTH);
    assign o_status.empty = r_count == '0;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= Q_CNT_W'(QUEUE_DEPTH))
        else $error("queue fill count beyond its depth");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && o_status.full) || (i_pop && o_status.empty) |-> 1'b0)
        else $error("queue pushed while full or popped while empty");

endmodule

// File: rtl/cpbd_back.sv
// Back end: scales the corners, rounds, clips to the frame and holds the result.
module cpbd_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  cpbd_pkg::t_item              i_item,
    input  cpbd_pkg::t_q_status          i_status,
    output logic                         o_pop,
    input  logic [cpbd_pkg::PPC_W-1:0]   i_ppc,
    input  logic [cpbd_pkg::FRAME_W-1:0] i_frame_w,
    input  logic [cpbd_pkg::FRAME_W-1:0] i_frame_h,
    cpbd_out_if.source                   o_box
);
    import cpbd_pkg::*;

    logic                     r_s1_valid;
    logic                     n_s1_valid;
    logic signed [PROD_W-1:0] r_p_lo_x;
    logic signed [PROD_W-1:0] r_p_hi_x;
    logic signed [PROD_W-1:0] r_p_lo_y;
    logic signed [PROD_W-1:0] r_p_hi_y;
    logic [HEAT_W-1:0]        r_s1_score;
    logic [CLASS_W-1:0]       r_s1_class;
    logic [CELL_W-1:0]        r_s1_px;
    logic [CELL_W-1:0]        r_s1_py;
    logic signed [PPC_W:0]    scale_s;
    logic                     s1_free;
    logic                     s2_free;
    t_span                    span_x;
    t_span                    span_y;

    logic                     r_o_valid;
    logic [POS_W-1:0]         r_box_x;
    logic [POS_W-1:0]         r_box_y;
    logic [FRAME_W-1:0]       r_box_w;
    logic [FRAME_W-1:0]       r_box_h;
    logic [HEAT_W-1:0]        r_score;
    logic [CLASS_W-1:0]       r_class;
    logic [CELL_W-1:0]        r_px;
    logic [CELL_W-1:0]        r_py;

    assign scale_s = $signed({1'b0, i_ppc});
    assign s2_free = !r_o_valid || o_box.ready;
    assign s1_free = !r_s1_valid || s2_free;
    assign o_pop = s1_free && !i_status.empty;
    assign n_s1_valid = o_pop || (r_s1_valid && !s2_free);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
        end
    end

    // One multiplier per corner coordinate; products are registered before rounding.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_p_lo_x <= i_item.lo_x * scale_s;
            r_p_hi_x <= i_item.hi_x * scale_s;
            r_p_lo_y <= i_item.lo_y * scale_s;
            r_p_hi_y <= i_item.hi_y * scale_s;
            r_s1_score <= i_item.score;
            r_s1_class <= i_item.out_class;
            r_s1_px <= i_item.peak_x;
            r_s1_py <= i_item.peak_y;
        end
    end

    assign span_x = axis_clip(r_p_lo_x, r_p_hi_x, i_frame_w);
    assign span_y = axis_clip(r_p_lo_y, r_p_hi_y, i_frame_h);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (s2_free) begin
            r_o_valid <= r_s1_valid && span_x.ok && span_y.ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_free) begin
            r_box_x <= span_x.start;
            r_box_y <= span_y.start;
            r_box_w <= span_x.len;
            r_box_h <= span_y.len;
            r_score <= r_s1_score;
            r_class <= r_s1_class;
            r_px <= r_s1_px;
            r_py <= r_s1_py;
        end
    end

    assign o_box.valid = r_o_valid;
    assign o_box.box_x = r_box_x;
    assign o_box.box_y = r_box_y;
    assign o_box.box_w = r_box_w;
    assign o_box.box_h = r_box_h;
    assign o_box.score = r_score;
    assign o_box.out_class = r_class;
    assign o_box.peak_x = r_px;
    assign o_box.peak_y = r_py;

    a_box_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid |-> (r_box_w != '0) && (r_box_h != '0)
                   && ((15'(r_box_x) + 15'(r_box_w)) <= 15'(FRAME_MAX))
                   && ((15'(r_box_y) + 15'(r_box_h)) <= 15'(FRAME_MAX)))
        else $error("emitted box is empty or leaves the frame");

    a_s1_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !s2_free |=> r_s1_valid && $stable(r_p_lo_x) && $stable(r_s1_score))
        else $error("product stage lost an item while the output was stalled");

endmodule

// File: rtl/centernet_peak_box_decode.sv
// A peak accepted passes the front register, queue, product and output registers in turn.
// Throughput: one cell per cycle unless a full queue stalls it; every stage is elastic.
// Cells that are not peaks, or whose box clips to nothing, produce no transaction.
// Reset (synchronous, active low) empties the front register, queue and back pipeline
// and loads the configuration registers with their default values.
module centernet_peak_box_decode #(
    parameter int NUM_CLASSES = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cpbd_in_if.sink    i_cell,
    cpbd_cfg_if.sink   i_cfg,
    cpbd_out_if.source o_box
);
    import cpbd_pkg::*;

    t_cfg      r_cfg;
    t_cfg      n_cfg;
    logic      push;
    logic      pop;
    t_item     front_item;
    t_item     queue_item;
    t_q_status q_status;

    assign i_cfg.ready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            unique case (t_cfg_reg'(i_cfg.index))
                CFG_SCORE_THRESHOLD: n_cfg.score_threshold = HEAT_W'(i_cfg.data);
                CFG_PIXELS_PER_CELL: n_cfg.pixels_per_cell = PPC_W'(i_cfg.data);
                CFG_IMG_W:           n_cfg.img_w = FRAME_W'(i_cfg.data);
                CFG_IMG_H:           n_cfg.img_h = FRAME_W'(i_cfg.data);
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.score_threshold <= RST_THRESHOLD;
            r_cfg.pixels_per_cell <= RST_PPC;
            r_cfg.img_w <= RST_IMG_W;
            r_cfg.img_h <= RST_IMG_H;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    cpbd_front #(
        .NUM_CLASSES(NUM_CLASSES)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cell           (i_cell),
        .i_score_threshold(r_cfg.score_threshold),
        .i_q              (q_status),
        .o_push           (push),
        .o_item           (front_item)
    );

    cpbd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .i_pop   (pop),
        .o_item  (queue_item),
        .o_status(q_status)
    );

    cpbd_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (queue_item),
        .i_status (q_status),
        .o_pop    (pop),
        .i_ppc    (r_cfg.pixels_per_cell),
        .i_frame_w(r_cfg.img_w),
        .i_frame_h(r_cfg.img_h),
        .o_box    (o_box)
    );

endmodule
